>>> sv/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types, codes, hash constants and the shift-xor mix step of the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int unsigned BUCKETS_DEF = 32;
    localparam int unsigned ENTRIES_DEF = 64;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned MIX_SHIFT = 33;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_DUP      = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [63:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_value;
    } rsp_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        BE_IDLE,
        BE_MUL1,
        BE_MUL2,
        BE_HEAD,
        BE_RD,
        BE_CMP,
        BE_FREE,
        BE_FREE_WAIT,
        BE_FIN,
        BE_LINK,
        BE_CLEAR
    } be_state_t;

    function automatic logic [63:0] xs33(input logic [63:0] k);
        xs33 = k ^ (k >> MIX_SHIFT);
    endfunction

endpackage

>>> sv/chte_ram.sv
// ----------------------------------------------------------------------------
// chte_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chte_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/chte_front.sv
// ----------------------------------------------------------------------------
// chte_front
// Command front end: a two-entry queue that accepts commands and holds them for the back end.
// ----------------------------------------------------------------------------
module chte_front
    import chte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic q_valid,
    input  logic q_take,
    output req_t q_req
);

    req_t        slot_reg [2];
    logic        rd_ptr_reg, wr_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;
    // unused command codes are passed as-is; the back end treats them as no-ops
    assign q_req   = slot_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= req;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> cnt_reg <= 2'd2) else $error("front queue overflow");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("front queue count mismatch");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !do_pop) else $error("pop from empty front queue");
`endif

endmodule

>>> sv/chte_back.sv
// ----------------------------------------------------------------------------
// chte_back
// Back end: hashes the key, walks the bucket chain and updates the table.
// ----------------------------------------------------------------------------
module chte_back
    import chte_pkg::*;
#(
    parameter int unsigned BUCKETS = BUCKETS_DEF,
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_take,
    input  req_t q_req,
    output logic empty,
    input  logic pop,
    output rsp_t rsp
);

    localparam int unsigned BW = $clog2(BUCKETS);
    localparam int unsigned EW = $clog2(ENTRIES);
    localparam int unsigned LW = EW + 1;
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);

    be_state_t  state_reg, state_next;
    req_t       req_reg, req_next;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  ph_reg, ph_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [LW-1:0] fcnt_reg, fcnt_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic          hit_reg, hit_next;
    logic          rv_reg, rv_next;
    rsp_t          out_reg, out_next;

    // partial product unit
    logic [63:0] mul_c;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p, mul_sum;

    // memory ports
    logic          hd_we;  logic [BW-1:0] hd_wa, hd_ra; logic [LW-1:0] hd_wd, hd_rd;
    logic          ky_we;  logic [EW-1:0] ky_wa, ky_ra; logic [63:0] ky_wd, ky_rd;
    logic          vl_we;  logic [EW-1:0] vl_wa, vl_ra; logic [63:0] vl_wd, vl_rd;
    logic          lk_we;  logic [EW-1:0] lk_wa, lk_ra; logic [LW-1:0] lk_wd, lk_rd;
    logic          fs_we;  logic [EW-1:0] fs_wa, fs_ra; logic [EW-1:0] fs_wd, fs_rd;
    logic [LW-1:0] fs_top;

    chte_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (.clk(clk), .we(hd_we),
        .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
    chte_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key (.clk(clk), .we(ky_we),
        .waddr(ky_wa), .wdata(ky_wd), .raddr(ky_ra), .rdata(ky_rd));
    chte_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_val (.clk(clk), .we(vl_we),
        .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd));
    chte_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link (.clk(clk), .we(lk_we),
        .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
    chte_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_free (.clk(clk), .we(fs_we),
        .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

    assign empty = !rv_reg;
    assign rsp   = out_reg;
    assign fs_top = fcnt_reg - LW'(1);

    // free stack: slots below the lowest free count ever reached are taken to
    // hold their own index; slots at or above it have been rewritten by erases
    logic [LW-1:0] fill_reg, fill_next;
    logic [EW-1:0] fs_val;
    logic          fs_lo_reg;
    assign fs_val = fs_lo_reg ? fs_rd : fs_top[EW-1:0];

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_CLEAR;
            clr_reg   <= '0;
            fcnt_reg  <= NIL;
            fill_reg  <= NIL;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            fcnt_reg  <= fcnt_next;
            fill_reg  <= fill_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        hash_reg  <= hash_next;
        acc_reg   <= acc_next;
        ph_reg    <= ph_next;
        bkt_reg   <= bkt_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
        fs_lo_reg <= (fs_top >= fill_reg);
    end

    // 64x64 low product built from three 32x32 partial products, one per cycle
    always_comb
    begin
        mul_c = (state_reg == BE_MUL2) ? MIX_C2 : MIX_C1;
        unique case (ph_reg)
            2'd0:
            begin
                mul_a = hash_reg[31:0];
                mul_b = mul_c[31:0];
            end
            2'd1:
            begin
                mul_a = hash_reg[31:0];
                mul_b = mul_c[63:32];
            end
            default:
            begin
                mul_a = hash_reg[63:32];
                mul_b = mul_c[31:0];
            end
        endcase
        mul_p   = {32'h0, mul_a} * {32'h0, mul_b};
        mul_sum = acc_reg + {mul_p[31:0], 32'h0};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        hash_next  = hash_reg;
        acc_next   = acc_reg;
        ph_next    = ph_reg;
        bkt_next   = bkt_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        hit_next   = hit_reg;
        fcnt_next  = fcnt_reg;
        fill_next  = fill_reg;
        clr_next   = clr_reg;
        out_next   = out_reg;
        rv_next    = rv_reg;
        q_take     = 1'b0;
        hd_we = 1'b0; hd_wa = bkt_reg; hd_wd = NIL; hd_ra = bkt_reg;
        ky_we = 1'b0; ky_wa = '0; ky_wd = req_reg.key; ky_ra = cur_reg[EW-1:0];
        vl_we = 1'b0; vl_wa = '0; vl_wd = req_reg.value; vl_ra = cur_reg[EW-1:0];
        lk_we = 1'b0; lk_wa = '0; lk_wd = NIL; lk_ra = cur_reg[EW-1:0];
        fs_we = 1'b0; fs_wa = fcnt_reg[EW-1:0]; fs_wd = cur_reg[EW-1:0];
        fs_ra = fs_top[EW-1:0];

        if (pop && rv_reg)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            BE_CLEAR:
            begin
                hd_we = 1'b1;
                hd_wa = clr_reg;
                clr_next = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1)) state_next = BE_IDLE;
            end
            BE_IDLE:
            begin
                if (q_valid && (!rv_reg || pop))
                begin
                    q_take    = 1'b1;
                    req_next  = q_req;
                    hash_next = xs33(q_req.key);
                    ph_next   = '0;
                    state_next = BE_MUL1;
                end
            end
            BE_MUL1:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                    acc_next = mul_p;
                else if (ph_reg == 2'd1)
                    acc_next = mul_sum;
                else
                begin
                    hash_next  = xs33(mul_sum);
                    ph_next    = '0;
                    state_next = BE_MUL2;
                end
            end
            BE_MUL2:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                    acc_next = mul_p;
                else if (ph_reg == 2'd1)
                    acc_next = mul_sum;
                else
                begin
                    hash_next  = xs33(mul_sum);
                    bkt_next   = hash_next[BW-1:0];
                    ph_next    = '0;
                    state_next = BE_HEAD;
                end
            end
            BE_HEAD:
            begin
                // head read issued; result lands next cycle
                prev_next  = NIL;
                steps_next = '0;
                hit_next   = 1'b0;
                state_next = BE_RD;
            end
            BE_RD:
            begin
                cur_next = (steps_reg == '0) ? hd_rd : cur_reg;
                if (cur_next >= NIL || steps_reg >= NIL)
                    state_next = BE_FREE;
                else
                begin
                    lk_ra = cur_next[EW-1:0];
                    ky_ra = cur_next[EW-1:0];
                    vl_ra = cur_next[EW-1:0];
                    state_next = BE_CMP;
                end
            end
            BE_CMP:
            begin
                if (ky_rd == req_reg.key)
                begin
                    hit_next   = 1'b1;
                    state_next = BE_FREE;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = lk_rd;
                    steps_next = steps_reg + LW'(1);
                    if (lk_rd >= NIL || steps_next >= NIL)
                        state_next = BE_FREE;
                    else
                    begin
                        ky_ra = lk_rd[EW-1:0];
                        vl_ra = lk_rd[EW-1:0];
                        lk_ra = lk_rd[EW-1:0];
                        state_next = BE_CMP;
                    end
                end
            end
            BE_FREE:
            begin
                // free stack top read issued; key/value/link data still held
                state_next = BE_FREE_WAIT;
            end
            BE_FREE_WAIT:
            begin
                state_next = BE_FIN;
            end
            BE_FIN:
            begin
                out_next.status      = ST_NOTFOUND;
                out_next.found_value = '0;
                state_next           = BE_IDLE;
                rv_next              = 1'b1;
                priority case (req_reg.cmd)
                    CMD_INSERT:
                    begin
                        if (hit_reg)
                            out_next.status = ST_DUP;
                        else if (fcnt_reg == '0)
                            out_next.status = ST_FULL;
                        else
                        begin
                            fcnt_next = fs_top;
                            if (fs_top < fill_reg) fill_next = fs_top;
                            ky_we = 1'b1; ky_wa = fs_val;
                            vl_we = 1'b1; vl_wa = fs_val;
                            lk_we = 1'b1; lk_wa = fs_val; lk_wd = NIL;
                            if (prev_reg < NIL)
                            begin
                                // tail link written in the following cycle
                                cur_next   = {1'b0, fs_val};
                                state_next = BE_LINK;
                            end
                            else
                            begin
                                hd_we = 1'b1; hd_wd = {1'b0, fs_val};
                            end
                            out_next.status = ST_OK;
                        end
                    end
                    CMD_ERASE:
                    begin
                        if (hit_reg)
                        begin
                            if (prev_reg < NIL)
                            begin
                                lk_we = 1'b1; lk_wa = prev_reg[EW-1:0]; lk_wd = lk_rd;
                            end
                            else
                            begin
                                hd_we = 1'b1; hd_wd = lk_rd;
                            end
                            fs_we = 1'b1;
                            fcnt_next = fcnt_reg + LW'(1);
                            out_next.status = ST_OK;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (hit_reg)
                        begin
                            out_next.status      = ST_OK;
                            out_next.found_value = vl_rd;
                        end
                    end
                    default: ;
                endcase
            end
            BE_LINK:
            begin
                // append the new entry behind the old chain tail
                lk_we = 1'b1; lk_wa = prev_reg[EW-1:0]; lk_wd = cur_reg;
                state_next = BE_IDLE;
            end
            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= NIL) else $error("free count out of range");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && !pop) |=> rv_reg && $stable(out_reg))
        else $error("result changed while stalled");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> state_reg == BE_IDLE) else $error("command taken while busy");
`endif

endmodule

>>> sv/chained_hash_table_engine_core.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_core
// Chained key/value hash table with insert, erase and find commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through a queue-style port: a transaction happens when
//   push is high and full is low. Results leave the same way: while empty
//   is low the oldest result sits on rsp, and pop with empty low takes it.
//   Every command gives exactly one result.
//   A two-entry front queue decouples the port from the back end, which
//   takes a queued command when idle, hashes the key in two multiply
//   steps of three 32x32 partial products each (one partial product per
//   cycle), reads the bucket head (states HEAD and RD), spends one cycle
//   per chain entry visited, then reads the free stack and finishes
//   (states FREE, FREE_WAIT and FIN). The back end takes no new command
//   before it has finished the last one and its result has been taken
//   or is being popped.
//   An insert into a non-empty chain adds a LINK state for the tail link.
//   After reset the bucket heads are cleared, one per cycle; full stays
//   high only while the front queue is full.
//   When the receiver stalls, one result is held and the back end waits.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_core
    import chte_pkg::*;
#(
    parameter int unsigned BUCKETS = BUCKETS_DEF,
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic empty,
    input  logic pop,
    output rsp_t rsp
);

    logic q_valid, q_take;
    req_t q_req;

    chte_front u_front (.clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req(req), .q_valid(q_valid), .q_take(q_take), .q_req(q_req));

    chte_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (.clk(clk),
        .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_req(q_req),
        .empty(empty), .pop(pop), .rsp(rsp));

endmodule

>>> verif/tb_chained_hash_table_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_table_engine_core
// Self-checking bench for the chained hash table engine. A local model of
// the bucket chains and the free stack predicts status and found value for
// every command; directed, fill/drain, collision and random traffic with
// random gaps and a long receiver stall exercise the queue ports.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_engine_core;
    import chte_pkg::*;

    localparam int NB  = BUCKETS_DEF;
    localparam int NE  = ENTRIES_DEF;
    localparam int NIL = NE;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    req_t req;
    logic empty;
    logic pop;
    rsp_t rsp;

    chained_hash_table_engine_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

    // Table model
    int          head_q [NB];
    logic [63:0] key_m  [NE];
    logic [63:0] val_m  [NE];
    int          link_m [NE];
    int          free_stk [NE];
    int          free_cnt;

    rsp_t        rsp_exp_q [$];
    logic [63:0] live_keys [$];
    int          mismatches;
    int          hold_cycles;
    logic        hold_pop;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Murmur3 finalizer reduced to a bucket index
    function automatic int bucket_of(input logic [63:0] k);
        logic [63:0] h;
        h = k ^ (k >> 33);
        h = h * 64'hff51afd7ed558ccd;
        h = h ^ (h >> 33);
        h = h * 64'hc4ceb9fe1a85ec53;
        h = h ^ (h >> 33);
        return int'(h % NB);
    endfunction

    // Apply one command to the model and queue its expected result
    task automatic table_apply(input req_t r);
        int   b, cur, prv, hit, steps, e;
        rsp_t o;
        b     = bucket_of(r.key);
        cur   = head_q[b];
        prv   = NIL;
        hit   = NIL;
        steps = 0;
        while (cur < NIL && steps < NE && hit == NIL) begin
            if (key_m[cur] == r.key)
                hit = cur;
            else
            begin
                prv = cur;
                cur = link_m[cur];
            end
            steps++;
        end
        o.status      = ST_NOTFOUND;
        o.found_value = '0;
        case (cmd_t'(r.cmd))
            CMD_INSERT:
            begin
                if (hit < NIL)
                    o.status = ST_DUP;
                else if (free_cnt == 0)
                    o.status = ST_FULL;
                else
                begin
                    free_cnt--;
                    e         = free_stk[free_cnt];
                    key_m[e]  = r.key;
                    val_m[e]  = r.value;
                    link_m[e] = NIL;
                    if (prv < NIL)
                        link_m[prv] = e;
                    else
                        head_q[b] = e;
                    o.status = ST_OK;
                    live_keys.push_back(r.key);
                end
            end
            CMD_ERASE:
            begin
                if (hit < NIL)
                begin
                    if (prv < NIL)
                        link_m[prv] = link_m[hit];
                    else
                        head_q[b] = link_m[hit];
                    key_m[hit]  = '0;
                    val_m[hit]  = '0;
                    link_m[hit] = NIL;
                    free_stk[free_cnt] = hit;
                    free_cnt++;
                    o.status = ST_OK;
                    foreach (live_keys[i])
                        if (live_keys[i] == r.key)
                        begin
                            live_keys.delete(i);
                            break;
                        end
                end
            end
            CMD_FIND:
            begin
                if (hit < NIL)
                begin
                    o.status      = ST_OK;
                    o.found_value = val_m[hit];
                end
            end
            default: ;
        endcase
        rsp_exp_q.push_back(o);
    endtask

    // Send one command after a random gap
    task automatic send_cmd(input cmd_t c, input logic [63:0] k, input logic [63:0] v);
        int   gap;
        req_t r;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        r.cmd   = c;
        r.key   = k;
        r.value = v;
        push <= 1'b1;
        req  <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        table_apply(r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Pick a key that is likely present
    function automatic logic [63:0] pick_key();
        if (live_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        return rand64();
    endfunction

    // Receiver: random pop gaps, optional long hold-off
    initial
    begin
        int gap;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else if (!pop || !empty)
            begin
                gap = $urandom_range(0, 6);
                if ($urandom_range(0, 2) == 0)
                    gap = 0;
                if (gap > 0 && !hold_pop)
                begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                pop <= 1'b1;
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && pop && !empty)
        begin
            if (rsp_exp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: status %0d value %h",
                             rsp.status, rsp.found_value);
            end
            else
            begin
                e = rsp_exp_q.pop_front();
                if (rsp.status !== e.status || rsp.found_value !== e.found_value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp status %0d value %h, got %0d %h",
                                 e.status, e.found_value, rsp.status, rsp.found_value);
                end
            end
        end
    end

    task automatic drain();
        push <= 1'b0;
        while (rsp_exp_q.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, every command, unused code, absent keys, duplicates
    task automatic test_directed();
        send_cmd(CMD_FIND,   64'h0, 64'h0);
        send_cmd(CMD_ERASE,  64'h0, 64'h0);
        send_cmd(CMD_INSERT, 64'h0, 64'hffff_ffff_ffff_ffff);
        send_cmd(CMD_INSERT, 64'hffff_ffff_ffff_ffff, 64'h0);
        send_cmd(CMD_INSERT, 64'h0, 64'h1234);
        send_cmd(CMD_FIND,   64'h0, 64'h0);
        send_cmd(CMD_FIND,   64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        send_cmd(CMD_NONE,   64'h0, 64'hffff_ffff_ffff_ffff);
        send_cmd(CMD_NONE,   64'hffff_ffff_ffff_ffff, 64'h5);
        send_cmd(CMD_ERASE,  64'hffff_ffff_ffff_ffff, 64'h0);
        send_cmd(CMD_ERASE,  64'hffff_ffff_ffff_ffff, 64'h0);
        send_cmd(CMD_FIND,   64'hffff_ffff_ffff_ffff, 64'h0);
        send_cmd(CMD_INSERT, 64'h8000_0000_0000_0001, 64'haaaa_5555_aaaa_5555);
        send_cmd(CMD_FIND,   64'h8000_0000_0000_0001, 64'h0);
        send_cmd(CMD_ERASE,  64'h0, 64'h0);
        send_cmd(CMD_ERASE,  64'h8000_0000_0000_0001, 64'h0);
        drain();
    endtask

    // Long chains in one bucket: tail duplicate, middle and head erase
    task automatic test_collisions();
        logic [63:0] k;
        logic [63:0] chain [$];
        k = rand64();
        while (chain.size() < 6)
        begin
            if (bucket_of(k) == 5)
                chain.push_back(k);
            k++;
        end
        foreach (chain[i])
            send_cmd(CMD_INSERT, chain[i], rand64());
        send_cmd(CMD_INSERT, chain[5], rand64());
        send_cmd(CMD_INSERT, chain[0], rand64());
        send_cmd(CMD_ERASE,  chain[2], 64'h0);
        send_cmd(CMD_FIND,   chain[3], 64'h0);
        send_cmd(CMD_ERASE,  chain[0], 64'h0);
        send_cmd(CMD_ERASE,  chain[5], 64'h0);
        send_cmd(CMD_INSERT, chain[2], rand64());
        foreach (chain[i])
            send_cmd(CMD_FIND, chain[i], 64'h0);
        foreach (chain[i])
            send_cmd(CMD_ERASE, chain[i], 64'h0);
        drain();
    endtask

    // Fill the table, hit full and duplicate-when-full, then empty it
    task automatic test_fill_drain();
        logic [63:0] k;
        while (free_cnt > 0)
            send_cmd(CMD_INSERT, rand64(), rand64());
        send_cmd(CMD_INSERT, rand64(), rand64());
        send_cmd(CMD_INSERT, live_keys[0], rand64());
        send_cmd(CMD_FIND, live_keys[NE - 1], 64'h0);
        while (live_keys.size() > 0)
        begin
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            send_cmd(CMD_ERASE, k, 64'h0);
        end
        drain();
    endtask

    // Receiver holds off while the sender keeps pushing
    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (20)
            send_cmd(cmd_t'($urandom_range(0, 2)), pick_key(), rand64());
        drain();
    endtask

    // Mostly valid commands on live keys, some noise
    task automatic test_random(input int n);
        int   sel;
        cmd_t c;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                c = CMD_INSERT;
            else if (sel < 65)
                c = CMD_ERASE;
            else if (sel < 97)
                c = CMD_FIND;
            else
                c = CMD_NONE;
            send_cmd(c, pick_key(), rand64());
        end
        drain();
    endtask

    // Main sequence
    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        req         = '0;
        mismatches  = 0;
        hold_cycles = 0;
        hold_pop    = 1'b0;
        for (int i = 0; i < NB; i++)
            head_q[i] = NIL;
        for (int i = 0; i < NE; i++)
        begin
            key_m[i]    = '0;
            val_m[i]    = '0;
            link_m[i]   = NIL;
            free_stk[i] = i;
        end
        free_cnt = NE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_collisions();
        test_fill_drain();
        test_backpressure();
        test_random(900);
        test_fill_drain();
        test_random(650);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && rsp_exp_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
